// ----- src/zsd_pkg.sv -----
// Shared types and constants for the ZX0 stream decompressor.
// No dependencies; used by the top level, the engine and the checker.
package zsd_pkg;

  localparam int WINDOW_BYTES_DEF = 32768;
  localparam int COUNT_BITS_DEF   = 24;
  localparam int LIMIT_BITS       = 24;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 24'hFFFFFF;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_BAD_OFS   = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic                  out_valid;
    logic [7:0]            out_byte;
    logic                  need_byte;
    logic [2:0]            status;
    logic [LIMIT_BITS-1:0] produced_count;
  } out_item_t;

endpackage

// ----- src/zx0_stream_decompressor_unit.sv -----
// Top level of the ZX0 v2 stream decompressor.
// Depends on zsd_pkg, zsd_fifo and zsd_engine.
//
// Items enter a two-entry input queue; the engine takes one at a time, parses
// the control bits one per cycle, and leaves one result per item in a
// two-entry result queue. Per item the engine consumes control bits or an
// offset low byte, and a copy reads the history through the registered RAM
// port; a full result queue holds the engine. out_limit is written on the cfg
// channel, which is always ready.
module zx0_stream_decompressor_unit import zsd_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_BITS-1:0] cfg_data
);
  logic [LIMIT_BITS-1:0] out_limit;
  logic      q_empty, q_pop, r_full, r_push;
  in_item_t  q_item;
  out_item_t r_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_limit <= cfg_data;
    end
  end

  zsd_fifo #(.WIDTH($bits(in_item_t))) u_inq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  zsd_engine #(.WINDOW_BYTES(WINDOW_BYTES), .COUNT_BITS(COUNT_BITS)) u_eng (
    .clk       (clk),
    .rst       (rst),
    .out_limit (out_limit),
    .in_empty  (q_empty),
    .in_data   (q_item),
    .in_pop    (q_pop),
    .out_full  (r_full),
    .out_data  (r_item),
    .out_push  (r_push)
  );

  zsd_fifo #(.WIDTH($bits(out_item_t))) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .wdata (r_item),
    .full  (r_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );
endmodule

// ----- src/zsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/zsd_fifo.sv -----
// Two-entry queue used at the input and between engine and result port.
// No dependencies.
module zsd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// ----- src/zsd_engine.sv -----
// Back end: bit-serial ZX0 parser, history window and result formation.
// Depends on zsd_pkg and zsd_ram.
module zsd_engine import zsd_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [LIMIT_BITS-1:0] out_limit,
  input  logic                  in_empty,
  input  in_item_t              in_data,
  output logic                  in_pop,
  input  logic                  out_full,
  output out_item_t             out_data,
  output logic                  out_push
);
  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [31:0] CMASK = 32'hFFFFFFFF >> (32 - COUNT_BITS);
  localparam logic [31:0] WIN32 = 32'(WINDOW_BYTES);
  localparam logic [24:0] GMAX  = 25'h1FFFFFF;
  localparam logic [3:0] PH_LIT_LEN   = 4'd0;
  localparam logic [3:0] PH_REP_LEN   = 4'd2;
  localparam logic [3:0] PH_OFS_MSB   = 4'd4;
  localparam logic [3:0] PH_NEW_LEN   = 4'd6;
  localparam logic [3:0] PH_COPY_LIT  = 4'd8;
  localparam logic [3:0] PH_AFTER_LIT = 4'd9;
  localparam logic [3:0] PH_COPY      = 4'd10;
  localparam logic [3:0] PH_AFTER_CPY = 4'd11;
  localparam logic [3:0] PH_OFS_LOW   = 4'd12;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_READ, S_DONE} state_t;

  state_t              state, state_next;
  logic [3:0]          phase, phase_next;
  logic [24:0]         acc, acc_next;
  logic [24:0]         rem, rem_next;
  logic [7:0]          bbuf, bbuf_next;
  logic [7:0]          bmask, bmask_next;
  logic                reuse, reuse_next;
  logic [7:0]          held, held_next;
  logic                fseen, fseen_next;
  logic [2:0]          rstat, rstat_next;
  logic [COUNT_BITS-1:0] wp, wp_next;
  logic [31:0]         poff, poff_next;
  logic                slot_full, slot_full_next;
  logic [7:0]          slot_byte, slot_byte_next;
  logic                slot_final, slot_final_next;
  out_item_t           res, res_next;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic        tb_ok, tb_need, tb_bit, tb_buf, tb_byte;
  logic        gbit;
  logic [31:0] wp32, lim32;
  logic        fin, f_valid, f_need;
  logic [7:0]  f_byte;

  zsd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_data = res;
  assign wp32     = 32'(wp);
  assign lim32    = (32'(out_limit) < CMASK) ? 32'(out_limit) : CMASK;

  always_comb begin
    tb_ok   = 1'b0;
    tb_need = 1'b0;
    tb_bit  = 1'b0;
    tb_buf  = 1'b0;
    tb_byte = 1'b0;
    if (reuse) begin
      tb_ok  = 1'b1;
      tb_bit = held[0];
    end else if (bmask > 8'd1) begin
      tb_ok  = 1'b1;
      tb_buf = 1'b1;
      tb_bit = |(bbuf & (bmask >> 1));
    end else if (!fseen && slot_full) begin
      tb_ok   = 1'b1;
      tb_byte = 1'b1;
      tb_bit  = slot_byte[7];
    end else begin
      tb_need = !fseen;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    acc_next        = acc;
    rem_next        = rem;
    bbuf_next       = bbuf;
    bmask_next      = bmask;
    reuse_next      = reuse;
    held_next       = held;
    fseen_next      = fseen;
    rstat_next      = rstat;
    wp_next         = wp;
    poff_next       = poff;
    slot_full_next  = slot_full;
    slot_byte_next  = slot_byte;
    slot_final_next = slot_final;
    res_next        = res;
    ram_we          = 1'b0;
    ram_wdata       = 8'd0;
    ram_raddr       = AW'(wp32 - poff);
    in_pop          = 1'b0;
    out_push        = 1'b0;
    fin             = 1'b0;
    f_valid         = 1'b0;
    f_need          = 1'b0;
    f_byte          = 8'd0;
    gbit            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!in_empty) begin
          in_pop          = 1'b1;
          slot_full_next  = (in_data.kind == KIND_BYTE);
          slot_byte_next  = in_data.data_byte;
          slot_final_next = in_data.final_byte;
          state_next      = S_RUN;
        end
      end
      S_RUN: begin
        if (rstat != ST_RUNNING) begin
          fin = 1'b1;
        end else if (phase < PH_COPY_LIT || phase == PH_AFTER_LIT ||
                     phase == PH_AFTER_CPY) begin
          if (!tb_ok) begin
            fin    = 1'b1;
            f_need = tb_need;
            if (!tb_need) rstat_next = ST_EXHAUSTED;
          end else begin
            if (reuse) begin
              reuse_next = 1'b0;
            end else if (tb_buf) begin
              bmask_next = bmask >> 1;
            end else if (tb_byte) begin
              slot_full_next = 1'b0;
              held_next      = slot_byte;
              fseen_next     = fseen | slot_final;
              bbuf_next      = slot_byte;
              bmask_next     = 8'h80;
            end
            if (phase == PH_AFTER_LIT || phase == PH_AFTER_CPY) begin
              acc_next = 25'd1;
              if (tb_bit) phase_next = PH_OFS_MSB;
              else phase_next = (phase == PH_AFTER_LIT) ? PH_REP_LEN : PH_LIT_LEN;
            end else if (phase[0]) begin
              gbit       = tb_bit ^ (phase[2:1] == 2'b10);
              acc_next   = (acc > (GMAX >> 1)) ? GMAX : {acc[23:0], gbit};
              phase_next = {phase[3:1], 1'b0};
            end else if (!tb_bit) begin
              phase_next = {phase[3:1], 1'b1};
            end else begin
              unique case (phase)
                PH_LIT_LEN: begin
                  rem_next   = acc;
                  phase_next = PH_COPY_LIT;
                end
                PH_REP_LEN: begin
                  rem_next   = acc;
                  phase_next = PH_COPY;
                end
                PH_OFS_MSB: begin
                  if (acc == 25'd256) begin
                    rstat_next = ST_DONE;
                    fin        = 1'b1;
                  end else begin
                    phase_next = PH_OFS_LOW;
                  end
                end
                default: begin
                  rem_next   = (acc < GMAX) ? acc + 25'd1 : GMAX;
                  phase_next = PH_COPY;
                end
              endcase
            end
          end
        end else begin
          unique case (phase)
            PH_COPY_LIT: begin
              if (fseen) begin
                rstat_next = ST_EXHAUSTED;
                fin        = 1'b1;
              end else if (!slot_full) begin
                fin    = 1'b1;
                f_need = 1'b1;
              end else begin
                slot_full_next = 1'b0;
                held_next      = slot_byte;
                fseen_next     = slot_final;
                fin            = 1'b1;
                if (wp32 >= lim32) begin
                  rstat_next = ST_LIMIT;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = slot_byte;
                  wp_next   = wp + COUNT_BITS'(1);
                  f_valid   = 1'b1;
                  f_byte    = slot_byte;
                  rem_next  = rem - 25'd1;
                  if (rem == 25'd1) phase_next = PH_AFTER_LIT;
                end
              end
            end
            PH_COPY: begin
              if (poff > wp32 || poff > WIN32) begin
                rstat_next = ST_BAD_OFS;
                fin        = 1'b1;
              end else if (wp32 >= lim32) begin
                rstat_next = ST_LIMIT;
                fin        = 1'b1;
              end else begin
                state_next = S_READ;
              end
            end
            PH_OFS_LOW: begin
              if (fseen) begin
                rstat_next = ST_EXHAUSTED;
                fin        = 1'b1;
              end else if (!slot_full) begin
                fin    = 1'b1;
                f_need = 1'b1;
              end else begin
                slot_full_next = 1'b0;
                held_next      = slot_byte;
                fseen_next     = slot_final;
                poff_next      = {acc, 7'd0} - 32'(slot_byte[7:1]);
                reuse_next     = 1'b1;
                acc_next       = 25'd1;
                phase_next     = PH_NEW_LEN;
              end
            end
            default: begin
              acc_next   = 25'd1;
              phase_next = PH_LIT_LEN;
            end
          endcase
        end
      end
      S_READ: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        wp_next   = wp + COUNT_BITS'(1);
        fin       = 1'b1;
        f_valid   = 1'b1;
        f_byte    = ram_rdata;
        if (rem <= 25'd1) begin
          rem_next   = 25'd0;
          phase_next = PH_AFTER_CPY;
        end else begin
          rem_next = rem - 25'd1;
        end
      end
      S_DONE: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      state_next              = S_DONE;
      res_next.out_valid      = f_valid;
      res_next.out_byte       = f_byte;
      res_next.need_byte      = f_need;
      res_next.status         = rstat_next;
      res_next.produced_count = LIMIT_BITS'(32'(wp_next));
    end
  end

  always_ff @(posedge clk) begin
    res        <= res_next;
    bbuf       <= bbuf_next;
    held       <= held_next;
    slot_byte  <= slot_byte_next;
    slot_final <= slot_final_next;
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LIT_LEN;
      acc       <= 25'd1;
      rem       <= 25'd0;
      bmask     <= 8'd0;
      reuse     <= 1'b0;
      fseen     <= 1'b0;
      rstat     <= ST_RUNNING;
      wp        <= '0;
      poff      <= 32'd1;
      slot_full <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      acc       <= acc_next;
      rem       <= rem_next;
      bmask     <= bmask_next;
      reuse     <= reuse_next;
      fseen     <= fseen_next;
      rstat     <= rstat_next;
      wp        <= wp_next;
      poff      <= poff_next;
      slot_full <= slot_full_next;
    end
  end
endmodule

// ----- src/zsd_checker.sv -----
// Port-level checks for the decompressor, bound to the top level.
// Depends on zsd_pkg.
module zsd_props import zsd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input out_item_t out_item
);
  a_stop_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status != ST_RUNNING) |-> !out_item.out_valid)
    else $error("result with data after stop");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.out_valid) |-> (out_item.out_byte == 8'd0))
    else $error("nonzero byte without data");

  a_need_running: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.need_byte) |->
      (!out_item.out_valid && out_item.status == ST_RUNNING))
    else $error("need_byte with data or stop");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not clear after reset");
endmodule

bind zx0_stream_decompressor_unit zsd_props u_chk (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .out_item (out_item)
);
